/* rtl/pmc_pkg.sv */
// Shared types and constants for the pointer motion conditioner.
// Used by pmc_cfg_regs, pmc_ctrl, pmc_datapath and the top level; no dependencies.
package pmc_pkg;

  // Field and datapath widths
  localparam int unsigned DX_W      = 12;  // input motion count
  localparam int unsigned VAL_W     = 20;  // conditioned value (scaled or accelerated)
  localparam int unsigned SQ_W      = 24;  // square of a motion count
  localparam int unsigned MA_W      = 24;  // multiplier operand A
  localparam int unsigned MB_W      = 17;  // multiplier operand B
  localparam int unsigned PROD_W    = MA_W + MB_W;
  localparam int unsigned CHG_W     = 36;  // change fields, 12 fraction bits
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned MODE_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Acceleration constants
  localparam int unsigned ACCEL_LIMIT     = 3000;
  localparam int unsigned ACCEL_THRESHOLD = 40;

  // Mode flag bit positions
  localparam int unsigned MODE_SMOOTH      = 0;
  localparam int unsigned MODE_ACCEL       = 1;
  localparam int unsigned MODE_LOOK_STRAFE = 2;
  localparam int unsigned MODE_FREE_LOOK   = 3;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RST    = 4'd8;
  localparam logic [GAIN_W-1:0] SPEED_RST   = 16'd768;
  localparam logic [GAIN_W-1:0] SIDE_RST    = 16'd3277;
  localparam logic [GAIN_W-1:0] TURN_RST    = 16'd90;
  localparam logic [GAIN_W-1:0] TILT_RST    = 16'd90;
  localparam logic [GAIN_W-1:0] ADVANCE_RST = 16'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_FLAGS   = 3'd0,
    CFG_SPEED_SCALE  = 3'd1,
    CFG_SIDE_GAIN    = 3'd2,
    CFG_TURN_GAIN    = 3'd3,
    CFG_TILT_GAIN    = 3'd4,
    CFG_ADVANCE_GAIN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [GAIN_W-1:0] speed_scale;
    logic [GAIN_W-1:0] side_gain;
    logic [GAIN_W-1:0] turn_gain;
    logic [GAIN_W-1:0] tilt_gain;
    logic [GAIN_W-1:0] advance_gain;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCALE_X,
    OP_SCALE_Y,
    OP_SQ_X,
    OP_CUBE_X,
    OP_SQ_Y,
    OP_CUBE_Y,
    OP_GAIN_H,
    OP_GAIN_V,
    OP_ZERO
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic nonzero;   // some conditioned axis is non-zero
    logic accel_en;  // acceleration mode selected
    logic over_thr;  // some axis magnitude above the threshold
  } status_t;

endpackage

/* rtl/pmc_cfg_regs.sv */
// Configuration register file of the pointer motion conditioner.
// Depends on pmc_pkg for register indexes, widths and reset values.
module pmc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pmc_pkg::GAIN_W-1:0]     cfg_data_i,
  output pmc_pkg::cfg_t                  cfg_o
);
  import pmc_pkg::*;

  cfg_t cfg_q;

  // Always take writes; indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_RST;
      cfg_q.speed_scale  <= SPEED_RST;
      cfg_q.side_gain    <= SIDE_RST;
      cfg_q.turn_gain    <= TURN_RST;
      cfg_q.tilt_gain    <= TILT_RST;
      cfg_q.advance_gain <= ADVANCE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE_FLAGS:   cfg_q.mode         <= cfg_data_i[MODE_W-1:0];
        CFG_SPEED_SCALE:  cfg_q.speed_scale  <= cfg_data_i;
        CFG_SIDE_GAIN:    cfg_q.side_gain    <= cfg_data_i;
        CFG_TURN_GAIN:    cfg_q.turn_gain    <= cfg_data_i;
        CFG_TILT_GAIN:    cfg_q.tilt_gain    <= cfg_data_i;
        CFG_ADVANCE_GAIN: cfg_q.advance_gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pmc_datapath.sv */
// Datapath of the pointer motion conditioner: smoothing, one shared 24x17
// multiplier for scaling, cubing and gains, and the result registers.
// Depends on pmc_pkg; driven by pmc_ctrl through cmd_t and status_t.
module pmc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pmc_pkg::cfg_t                      cfg_i,
  input  pmc_pkg::cmd_t                      cmd_i,
  output pmc_pkg::status_t                   status_o,
  input  logic signed [pmc_pkg::DX_W-1:0]    delta_horizontal_i,
  input  logic signed [pmc_pkg::DX_W-1:0]    delta_vertical_i,
  input  logic                               strafe_held_i,
  input  logic                               look_held_i,
  output logic                               moved_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   side_change_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   yaw_change_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   pitch_change_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   forward_change_o
);
  import pmc_pkg::*;

  localparam logic signed [PROD_W-1:0] LimPos = PROD_W'(ACCEL_LIMIT);
  localparam logic signed [PROD_W-1:0] LimNeg = -LimPos;
  localparam logic signed [VAL_W-1:0]  ThrPos = VAL_W'(ACCEL_THRESHOLD);
  localparam logic signed [VAL_W-1:0]  ThrNeg = -ThrPos;

  // Average with the kept value, truncating toward zero, when |v| exceeds 1
  function automatic logic signed [DX_W-1:0] smooth_avg(
    input logic signed [DX_W-1:0] v,
    input logic signed [DX_W-1:0] p
  );
    logic signed [DX_W:0] s;
    logic signed [DX_W:0] a;
    s = {v[DX_W-1], v} + {p[DX_W-1], p};
    a = s + {{DX_W{1'b0}}, s[DX_W]};
    if (v > 12'sd1 || v < -12'sd1) begin
      smooth_avg = a[DX_W:1];
    end else begin
      smooth_avg = v;
    end
  endfunction

  logic signed [DX_W-1:0]   prev_h_q, prev_v_q;
  logic signed [VAL_W-1:0]  x_q, y_q;
  logic signed [SQ_W-1:0]   sq_q;
  logic                     strafe_q, look_q;
  logic                     moved_q;
  logic signed [CHG_W-1:0]  side_q, yaw_q, pitch_q, fwd_q;

  logic signed [DX_W-1:0]   x_ld, y_ld;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod, neg_prod, scl_sum, cub_sum, cub_div;
  logic signed [VAL_W-1:0]  scl_val, cub_val;
  logic signed [MA_W-1:0]   x_ext, y_ext;
  logic                     route_side, route_pitch;

  // Smooth incoming samples
  always_comb begin
    if (cfg_i.mode[MODE_SMOOTH]) begin
      x_ld = smooth_avg(delta_horizontal_i, prev_h_q);
      y_ld = smooth_avg(delta_vertical_i, prev_v_q);
    end else begin
      x_ld = delta_horizontal_i;
      y_ld = delta_vertical_i;
    end
  end

  assign x_ext = {{(MA_W-VAL_W){x_q[VAL_W-1]}}, x_q};
  assign y_ext = {{(MA_W-VAL_W){y_q[VAL_W-1]}}, y_q};

  assign route_side  = strafe_q | (cfg_i.mode[MODE_LOOK_STRAFE] & look_q);
  assign route_pitch = (look_q | cfg_i.mode[MODE_FREE_LOOK]) & ~strafe_q;

  // Select multiplier operands for the current step
  always_comb begin
    case (cmd_i.op)
      OP_SCALE_X: begin
        mul_a = x_ext;
        mul_b = $signed({1'b0, cfg_i.speed_scale});
      end
      OP_SCALE_Y: begin
        mul_a = y_ext;
        mul_b = $signed({1'b0, cfg_i.speed_scale});
      end
      OP_SQ_X: begin
        mul_a = x_ext;
        mul_b = x_q[MB_W-1:0];
      end
      OP_CUBE_X: begin
        mul_a = sq_q;
        mul_b = x_q[MB_W-1:0];
      end
      OP_SQ_Y: begin
        mul_a = y_ext;
        mul_b = y_q[MB_W-1:0];
      end
      OP_CUBE_Y: begin
        mul_a = sq_q;
        mul_b = y_q[MB_W-1:0];
      end
      OP_GAIN_H: begin
        mul_a = x_ext;
        mul_b = $signed({1'b0, route_side ? cfg_i.side_gain : cfg_i.turn_gain});
      end
      OP_GAIN_V: begin
        mul_a = y_ext;
        mul_b = $signed({1'b0, route_pitch ? cfg_i.tilt_gain : cfg_i.advance_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign neg_prod = -prod;

  // Divide by 256 and by 4 toward zero
  assign scl_sum = prod + $signed({{(PROD_W-8){1'b0}}, {8{prod[PROD_W-1]}}});
  assign scl_val = scl_sum[VAL_W+7:8];
  assign cub_sum = prod + $signed({{(PROD_W-2){1'b0}}, {2{prod[PROD_W-1]}}});
  assign cub_div = cub_sum >>> 2;

  // Clamp the accelerated value
  always_comb begin
    if (cub_div > LimPos) begin
      cub_val = LimPos[VAL_W-1:0];
    end else if (cub_div < LimNeg) begin
      cub_val = LimNeg[VAL_W-1:0];
    end else begin
      cub_val = cub_div[VAL_W-1:0];
    end
  end

  assign status_o.nonzero  = (x_q != '0) || (y_q != '0);
  assign status_o.accel_en = cfg_i.mode[MODE_ACCEL];
  assign status_o.over_thr = (x_q > ThrPos) || (x_q < ThrNeg) ||
                             (y_q > ThrPos) || (y_q < ThrNeg);

  // Hold the kept values across samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_h_q <= '0;
      prev_v_q <= '0;
    end else if (cmd_i.op == OP_LOAD) begin
      prev_h_q <= x_ld;
      prev_v_q <= y_ld;
    end
  end

  // Advance working and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q      <= {{(VAL_W-DX_W){x_ld[DX_W-1]}}, x_ld};
        y_q      <= {{(VAL_W-DX_W){y_ld[DX_W-1]}}, y_ld};
        strafe_q <= strafe_held_i;
        look_q   <= look_held_i;
      end
      OP_SCALE_X: x_q  <= scl_val;
      OP_SCALE_Y: y_q  <= scl_val;
      OP_SQ_X:    sq_q <= prod[SQ_W-1:0];
      OP_CUBE_X:  x_q  <= cub_val;
      OP_SQ_Y:    sq_q <= prod[SQ_W-1:0];
      OP_CUBE_Y:  y_q  <= cub_val;
      OP_GAIN_H: begin
        side_q <= route_side ? prod[CHG_W-1:0] : '0;
        yaw_q  <= route_side ? '0 : neg_prod[CHG_W-1:0];
      end
      OP_GAIN_V: begin
        pitch_q <= route_pitch ? prod[CHG_W-1:0] : '0;
        fwd_q   <= route_pitch ? '0 : neg_prod[CHG_W-1:0];
        moved_q <= 1'b1;
      end
      OP_ZERO: begin
        side_q  <= '0;
        yaw_q   <= '0;
        pitch_q <= '0;
        fwd_q   <= '0;
        moved_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign moved_o          = moved_q;
  assign side_change_o    = side_q;
  assign yaw_change_o     = yaw_q;
  assign pitch_change_o   = pitch_q;
  assign forward_change_o = fwd_q;

endmodule

/* rtl/pmc_ctrl.sv */
// Controller of the pointer motion conditioner: sequences the datapath steps
// for one sample and owns the input and output handshakes. Depends on pmc_pkg.
module pmc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  pmc_pkg::status_t status_i,
  output pmc_pkg::cmd_t    cmd_o
);
  import pmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCALE_X,
    S_SCALE_Y,
    S_SQ_X,
    S_CUBE_X,
    S_SQ_Y,
    S_CUBE_Y,
    S_GAIN_H,
    S_GAIN_V,
    S_ZERO
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register is free when empty or handed off at this edge
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status_i.nonzero) begin
          state_d = S_ZERO;
        end else if (!status_i.accel_en) begin
          state_d = S_SCALE_X;
        end else if (status_i.over_thr) begin
          state_d = S_SQ_X;
        end else begin
          state_d = S_GAIN_H;
        end
      end
      S_SCALE_X: begin
        cmd_o.op = OP_SCALE_X;
        state_d  = S_SCALE_Y;
      end
      S_SCALE_Y: begin
        cmd_o.op = OP_SCALE_Y;
        state_d  = S_GAIN_H;
      end
      S_SQ_X: begin
        cmd_o.op = OP_SQ_X;
        state_d  = S_CUBE_X;
      end
      S_CUBE_X: begin
        cmd_o.op = OP_CUBE_X;
        state_d  = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = S_CUBE_Y;
      end
      S_CUBE_Y: begin
        cmd_o.op = OP_CUBE_Y;
        state_d  = S_GAIN_H;
      end
      S_GAIN_H: begin
        // Hold until the previous result has left
        if (out_free) begin
          cmd_o.op = OP_GAIN_H;
          state_d  = S_GAIN_V;
        end
      end
      S_GAIN_V: begin
        cmd_o.op    = OP_GAIN_V;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_ZERO: begin
        if (out_free) begin
          cmd_o.op    = OP_ZERO;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A result is written only into a free result register
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_GAIN_H || cmd_o.op == OP_ZERO) |-> out_free)
    else $error("result register overwritten while occupied");

  // An accepted sample is evaluated next
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECIDE))
    else $error("accepted sample not evaluated");

  // Finishing the vertical gain presents a result
  a_gain_v_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GAIN_V) |=> out_valid_q)
    else $error("result not presented after final step");

  // Zero motion skips all arithmetic
  a_zero_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && !status_i.nonzero) |=> (state_q == S_ZERO))
    else $error("zero motion took an arithmetic path");
`endif

endmodule

/* rtl/pointer_motion_conditioner.sv */
// Pointer motion conditioner top level: config registers, controller, datapath.
// A sample is loaded from idle and judged in the decide state: no motion takes the zero
// step, unscaled acceleration below threshold the two gain steps, sensitivity scales
// both axes first, and cubing squares and cubes both. A new sample is taken only once
// the controller is back in idle, as the single shared multiplier steps through the
// axes; a stalled result delays the gain step. Reset is asynchronous and active low.
module pointer_motion_conditioner (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pmc_pkg::GAIN_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pmc_pkg::DX_W-1:0]    delta_horizontal_i,
  input  logic signed [pmc_pkg::DX_W-1:0]    delta_vertical_i,
  input  logic                               strafe_held_i,
  input  logic                               look_held_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               moved_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   side_change_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   yaw_change_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   pitch_change_o,
  output logic signed [pmc_pkg::CHG_W-1:0]   forward_change_o
);
  import pmc_pkg::*;

  // Reset restores register defaults and clears the kept smoothing values
  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pmc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pmc_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .status_o           (status),
    .delta_horizontal_i (delta_horizontal_i),
    .delta_vertical_i   (delta_vertical_i),
    .strafe_held_i      (strafe_held_i),
    .look_held_i        (look_held_i),
    .moved_o            (moved_o),
    .side_change_o      (side_change_o),
    .yaw_change_o       (yaw_change_o),
    .pitch_change_o     (pitch_change_o),
    .forward_change_o   (forward_change_o)
  );

endmodule
